FILE: design/two_port_byte_dma_controller_assert.svh
// assertion macros shared by the checker
`ifndef TWO_PORT_BYTE_DMA_CONTROLLER_ASSERT_SVH
`define TWO_PORT_BYTE_DMA_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TPDMA_AST_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpdma check failed");

// next-cycle implication, checked outside reset
`define TPDMA_AST_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpdma check failed");

`endif

FILE: design/tpdma_pkg.sv
`default_nettype none
package tpdma_pkg;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_XFER  = 2'd2,
        REQ_TIMER = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_ACK   = 3'd2,
        PH_XFER  = 3'd3,
        PH_WAITC = 3'd4
    } phase_t;

    typedef enum logic [3:0] {
        WS_IDLE = 4'd0,
        WS_R0B0 = 4'd1,
        WS_R0B1 = 4'd2,
        WS_R0B2 = 4'd3,
        WS_R0B3 = 4'd4,
        WS_R1B0 = 4'd5,
        WS_R1B1 = 4'd6,
        WS_R2B0 = 4'd7,
        WS_R2B1 = 4'd8,
        WS_R3B0 = 4'd9,
        WS_R3B1 = 4'd10,
        WS_R4B0 = 4'd11,
        WS_R4B1 = 4'd12,
        WS_R6B0 = 4'd13
    } wseq_t;

    localparam logic [7:0] CMD_RESET    = 8'hC3;
    localparam logic [7:0] CMD_LOAD     = 8'hCF;
    localparam logic [7:0] CMD_CONTINUE = 8'hD3;
    localparam logic [7:0] CMD_RSTSEQ   = 8'hBF;
    localparam logic [7:0] CMD_CLRSTAT  = 8'h8B;
    localparam logic [7:0] CMD_INITRD   = 8'hA7;
    localparam logic [7:0] CMD_ENABLE   = 8'h87;
    localparam logic [7:0] CMD_DISABLE  = 8'h83;
    localparam logic [7:0] CMD_RDMASK   = 8'hBB;

    localparam logic [0:0] CFG_COMPAT = 1'd0;
    localparam logic [0:0] CFG_TURBO  = 1'd1;

    typedef struct packed {
        logic        run;
        phase_t      phase;
        wseq_t       wseq;
        logic [7:0]  base;
        logic [2:0]  rseq;
        logic [7:0]  rmask;
        logic [15:0] pa_start;
        logic [15:0] pb_start;
        logic [15:0] blen;
        logic [15:0] src;
        logic [15:0] dst;
        logic [15:0] cnt;
        logic        dir;
        logic        aio;
        logic [1:0]  amode;
        logic        bio;
        logic [1:0]  bmode;
        logic [7:0]  presc;
        logic [1:0]  xmode;
        logic        autorst;
        logic [1:0]  status;
        logic [13:0] wtimer;
        logic        in_wait;
        logic        busreq_n;
        logic        bao_n;
    } state_t;

    typedef struct packed {
        logic [1:0]  req;
        logic [7:0]  wdata;
        logic [7:0]  src_data;
        logic [13:0] elapsed;
        logic        grant_n;
        logic        down_n;
        logic        up_busy;
        logic        delay;
    } item_t;

    typedef struct packed {
        logic [7:0]  rdata;
        logic        wr_valid;
        logic [15:0] wr_addr;
        logic        wr_is_io;
        logic [7:0]  wr_data;
        logic        irq;
    } result_t;

endpackage
`default_nettype wire

FILE: design/tpdma_core.sv
`default_nettype none
module tpdma_core
(
    input  wire tpdma_pkg::state_t  cur,
    input  wire tpdma_pkg::item_t   item,
    input  wire                     compat,
    input  wire [1:0]               turbo,
    output tpdma_pkg::state_t       nxt,
    output tpdma_pkg::result_t      res
);

    function automatic logic wait_on(input logic [7:0] p, input logic [13:0] t);
        return (p != 8'd0) && (t[13:5] < {1'b0, p});
    endfunction

    function automatic logic [2:0] next_read(input logic [3:0] start, input logic [7:0] m);
        logic [2:0] r;
        logic       found;
        logic [3:0] b;
        r = 3'd0;
        found = 1'b0;
        for (int i = 0; i < 7; i++)
        begin
            b = start + 4'(i);
            if (b >= 4'd7)
                b = b - 4'd7;
            if (!found && m[b[2:0]])
            begin
                found = 1'b1;
                r = b[2:0];
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] step(input logic [15:0] a, input logic [1:0] md);
        logic [15:0] r;
        unique case (md)
            2'd1:    r = a + 16'd1;
            2'd0:    r = a - 16'd1;
            default: r = a;
        endcase
        return r;
    endfunction

    always_comb
    begin
        logic [7:0]  v;
        logic        go;
        logic [1:0]  smode;
        logic [1:0]  dmode;
        logic [15:0] pa;
        logic [15:0] pb;
        logic        block;
        nxt = cur;
        res = '0;
        v = item.wdata;
        go = 1'b0;
        smode = cur.dir ? cur.amode : cur.bmode;
        dmode = cur.dir ? cur.bmode : cur.amode;
        pa = cur.dir ? cur.src : cur.dst;
        pb = cur.dir ? cur.dst : cur.src;
        block = !item.down_n || item.up_busy || item.delay;
        unique case (tpdma_pkg::req_t'(item.req))
            tpdma_pkg::REQ_WRITE:
            begin
                if (cur.wseq != tpdma_pkg::WS_IDLE)
                begin
                    nxt.wseq = tpdma_pkg::WS_IDLE;
                    unique case (cur.wseq)
                        tpdma_pkg::WS_R0B0:
                        begin
                            nxt.pa_start[7:0] = v;
                            nxt.wseq = cur.base[4] ? tpdma_pkg::WS_R0B1 :
                                       cur.base[5] ? tpdma_pkg::WS_R0B2 :
                                       cur.base[6] ? tpdma_pkg::WS_R0B3 : tpdma_pkg::WS_IDLE;
                        end
                        tpdma_pkg::WS_R0B1:
                        begin
                            nxt.pa_start[15:8] = v;
                            nxt.wseq = cur.base[5] ? tpdma_pkg::WS_R0B2 :
                                       cur.base[6] ? tpdma_pkg::WS_R0B3 : tpdma_pkg::WS_IDLE;
                        end
                        tpdma_pkg::WS_R0B2:
                        begin
                            nxt.blen[7:0] = v;
                            nxt.wseq = cur.base[6] ? tpdma_pkg::WS_R0B3 : tpdma_pkg::WS_IDLE;
                        end
                        tpdma_pkg::WS_R0B3: nxt.blen[15:8] = v;
                        tpdma_pkg::WS_R1B0:
                            nxt.wseq = v[5] ? tpdma_pkg::WS_R1B1 : tpdma_pkg::WS_IDLE;
                        tpdma_pkg::WS_R2B0:
                            nxt.wseq = v[5] ? tpdma_pkg::WS_R2B1 : tpdma_pkg::WS_IDLE;
                        tpdma_pkg::WS_R2B1: nxt.presc = v;
                        tpdma_pkg::WS_R3B0:
                            nxt.wseq = cur.base[4] ? tpdma_pkg::WS_R3B1 : tpdma_pkg::WS_IDLE;
                        tpdma_pkg::WS_R4B0:
                        begin
                            nxt.pb_start[7:0] = v;
                            nxt.wseq = cur.base[3] ? tpdma_pkg::WS_R4B1 : tpdma_pkg::WS_IDLE;
                        end
                        tpdma_pkg::WS_R4B1: nxt.pb_start[15:8] = v;
                        tpdma_pkg::WS_R6B0:
                        begin
                            nxt.rmask = v;
                            nxt.rseq = next_read(4'd0, v);
                        end
                        default: nxt.wseq = tpdma_pkg::WS_IDLE;
                    endcase
                end
                else if ((v & 8'h83) == 8'h83)
                begin
                    nxt.wseq = tpdma_pkg::WS_IDLE;
                    unique case (v)
                        tpdma_pkg::CMD_RESET, tpdma_pkg::CMD_DISABLE:
                        begin
                            nxt.run = 1'b0;
                            nxt.phase = tpdma_pkg::PH_IDLE;
                            nxt.busreq_n = 1'b1;
                            nxt.bao_n = item.grant_n;
                            nxt.in_wait = 1'b0;
                            if (v == tpdma_pkg::CMD_RESET)
                            begin
                                nxt.status = 2'b00;
                                nxt.presc = 8'd0;
                                nxt.autorst = 1'b0;
                            end
                        end
                        tpdma_pkg::CMD_LOAD:
                        begin
                            nxt.status[1] = 1'b0;
                            nxt.src = cur.dir ? cur.pa_start : cur.pb_start;
                            nxt.dst = cur.dir ? cur.pb_start : cur.pa_start;
                            nxt.cnt = {16{compat}};
                        end
                        tpdma_pkg::CMD_CONTINUE:
                        begin
                            nxt.status[1] = 1'b0;
                            nxt.cnt = {16{compat}};
                        end
                        tpdma_pkg::CMD_RSTSEQ:  nxt.rseq = 3'd0;
                        tpdma_pkg::CMD_CLRSTAT: nxt.status = 2'b00;
                        tpdma_pkg::CMD_INITRD:  nxt.rseq = next_read(4'd0, cur.rmask);
                        tpdma_pkg::CMD_ENABLE:
                        begin
                            nxt.run = 1'b1;
                            nxt.phase = tpdma_pkg::PH_START;
                            nxt.status[0] = 1'b0;
                            nxt.in_wait = 1'b0;
                        end
                        tpdma_pkg::CMD_RDMASK:  nxt.wseq = tpdma_pkg::WS_R6B0;
                        default: ;
                    endcase
                end
                else if ((v & 8'hC7) == 8'h82)
                begin
                    nxt.base = v;
                    nxt.autorst = v[5];
                end
                else if ((v & 8'h83) == 8'h81)
                begin
                    nxt.base = v;
                    nxt.xmode = v[6:5];
                    nxt.wseq = v[2] ? tpdma_pkg::WS_R4B0 :
                               v[3] ? tpdma_pkg::WS_R4B1 : tpdma_pkg::WS_IDLE;
                end
                else if ((v & 8'h83) == 8'h80)
                begin
                    nxt.base = v;
                    if (v[6])
                    begin
                        nxt.run = 1'b1;
                        nxt.phase = tpdma_pkg::PH_START;
                        nxt.status[0] = 1'b0;
                        nxt.in_wait = 1'b0;
                    end
                    nxt.wseq = v[3] ? tpdma_pkg::WS_R3B0 :
                               v[4] ? tpdma_pkg::WS_R3B1 : tpdma_pkg::WS_IDLE;
                end
                else if ((v & 8'h87) == 8'h00)
                begin
                    nxt.base = v;
                    nxt.bio = v[3];
                    nxt.bmode = v[5:4];
                    nxt.wseq = v[6] ? tpdma_pkg::WS_R2B0 : tpdma_pkg::WS_IDLE;
                end
                else if ((v & 8'h87) == 8'h04)
                begin
                    nxt.base = v;
                    nxt.aio = v[3];
                    nxt.amode = v[5:4];
                    nxt.wseq = v[6] ? tpdma_pkg::WS_R1B0 : tpdma_pkg::WS_IDLE;
                end
                else if (!v[7] && (v[1:0] != 2'b00))
                begin
                    nxt.base = v;
                    nxt.dir = v[2];
                    nxt.wseq = v[3] ? tpdma_pkg::WS_R0B0 : v[4] ? tpdma_pkg::WS_R0B1 :
                               v[5] ? tpdma_pkg::WS_R0B2 : v[6] ? tpdma_pkg::WS_R0B3 :
                               tpdma_pkg::WS_IDLE;
                end
            end
            tpdma_pkg::REQ_READ:
            begin
                unique case (cur.rseq)
                    3'd0:    res.rdata = (cur.status[1] ? 8'h00 : 8'h20) | 8'h1A
                                         | {7'd0, cur.status[0]};
                    3'd1:    res.rdata = cur.cnt[7:0];
                    3'd2:    res.rdata = cur.cnt[15:8];
                    3'd3:    res.rdata = pa[7:0];
                    3'd4:    res.rdata = pa[15:8];
                    3'd5:    res.rdata = pb[7:0];
                    default: res.rdata = pb[15:8];
                endcase
                nxt.rseq = next_read({1'b0, cur.rseq} + 4'd1, cur.rmask);
            end
            tpdma_pkg::REQ_XFER:
            begin
                if (cur.run)
                begin
                    go = 1'b1;
                    if (cur.in_wait)
                    begin
                        if (wait_on(cur.presc, cur.wtimer))
                            go = 1'b0;
                        else
                            nxt.in_wait = 1'b0;
                    end
                end
                if (go)
                begin
                    // two-pass arbitration folded into one decision
                    unique case (cur.phase)
                        tpdma_pkg::PH_START:
                        begin
                            if (block)
                            begin
                                nxt.busreq_n = 1'b1;
                                nxt.bao_n = item.grant_n;
                            end
                            else
                            begin
                                nxt.busreq_n = 1'b0;
                                nxt.bao_n = 1'b1;
                                nxt.phase = item.grant_n ? tpdma_pkg::PH_ACK :
                                                           tpdma_pkg::PH_XFER;
                            end
                        end
                        tpdma_pkg::PH_ACK:
                        begin
                            if (!item.grant_n)
                                nxt.phase = tpdma_pkg::PH_XFER;
                            nxt.bao_n = 1'b1;
                        end
                        tpdma_pkg::PH_XFER:
                        begin
                            nxt.busreq_n = 1'b0;
                            nxt.bao_n = 1'b1;
                        end
                        default:
                        begin
                            nxt.busreq_n = 1'b1;
                            nxt.bao_n = item.grant_n;
                        end
                    endcase
                    if (nxt.phase == tpdma_pkg::PH_XFER)
                    begin
                        nxt.wtimer = 14'd0;
                        res.wr_valid = 1'b1;
                        res.wr_addr = cur.dst;
                        res.wr_is_io = cur.dir ? cur.bio : cur.aio;
                        res.wr_data = item.src_data;
                        nxt.cnt = cur.cnt + 16'd1;
                        nxt.status[0] = 1'b1;
                        nxt.src = step(cur.src, smode);
                        nxt.dst = step(cur.dst, dmode);
                        if (nxt.cnt >= cur.blen)
                        begin
                            nxt.status[1] = 1'b1;
                            res.irq = 1'b1;
                            if (cur.autorst)
                            begin
                                nxt.status[1] = 1'b0;
                                nxt.src = cur.dir ? cur.pa_start : cur.pb_start;
                                nxt.dst = cur.dir ? cur.pb_start : cur.pa_start;
                                nxt.cnt = {16{compat}};
                                nxt.phase = tpdma_pkg::PH_START;
                            end
                            else
                            begin
                                nxt.run = 1'b0;
                                nxt.phase = tpdma_pkg::PH_IDLE;
                                nxt.busreq_n = 1'b1;
                                nxt.bao_n = item.grant_n;
                            end
                            nxt.in_wait = 1'b0;
                        end
                        else if (item.delay)
                        begin
                            nxt.phase = tpdma_pkg::PH_START;
                            nxt.busreq_n = 1'b1;
                            nxt.bao_n = item.grant_n;
                        end
                        else if (cur.presc != 8'd0)
                        begin
                            // timer was just cleared, so any prescaler starts a wait
                            nxt.in_wait = 1'b1;
                            if (cur.xmode == 2'd2)
                            begin
                                nxt.phase = tpdma_pkg::PH_WAITC;
                                nxt.busreq_n = 1'b1;
                                nxt.bao_n = item.grant_n;
                            end
                        end
                    end
                end
            end
            default:
            begin
                nxt.wtimer = cur.wtimer + 14'(item.elapsed << (2'd3 - turbo));
                if (cur.phase == tpdma_pkg::PH_WAITC && !wait_on(cur.presc, nxt.wtimer))
                begin
                    if (block)
                    begin
                        nxt.phase = tpdma_pkg::PH_START;
                        nxt.busreq_n = 1'b1;
                        nxt.bao_n = item.grant_n;
                    end
                    else
                    begin
                        nxt.busreq_n = 1'b0;
                        nxt.bao_n = 1'b1;
                        nxt.phase = item.grant_n ? tpdma_pkg::PH_ACK : tpdma_pkg::PH_XFER;
                    end
                end
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: design/two_port_byte_dma_controller.sv
// an accepted input beat's result beat is registered and valid in the cycle after acceptance
// throughput: one beat per cycle while the result side takes each beat, the whole step is one pass through tpdma_core
// the input side stays ready while the result register drains or is taken
// reset (rst_n low, asynchronous) sets all controller state to its defaults and drops the result
`default_nettype none
module two_port_byte_dma_controller
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // wdata, src_data, elapsed_cycles, grant_n, downstream_req_n, upstream_busy,
    // delay_req, zero pad
    input  wire [tpdma_pkg::IN_DATA_W-1:0]   s_tdata,
    // req_type
    input  wire [tpdma_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // rdata, wr_valid, wr_addr, wr_is_io, wr_data, src_addr, src_is_io, busreq_n,
    // bao_n, holds_bus, block_end_irq, active
    output logic [tpdma_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire                              cfg_we,
    input  wire [0:0]                        cfg_index,
    input  wire [1:0]                        cfg_wdata
);

    tpdma_pkg::state_t  state_reg;
    tpdma_pkg::state_t  state_next;
    tpdma_pkg::item_t   item;
    tpdma_pkg::result_t res;
    logic               compat_reg;
    logic [1:0]         turbo_reg;
    logic               out_valid_reg;
    logic [tpdma_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic               accept;

    // take a new beat whenever the result slot is free or being emptied
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // unpack the input beat
    assign item.req      = s_tuser;
    assign item.wdata    = s_tdata[7:0];
    assign item.src_data = s_tdata[15:8];
    assign item.elapsed  = s_tdata[29:16];
    assign item.grant_n  = s_tdata[30];
    assign item.down_n   = s_tdata[31];
    assign item.up_busy  = s_tdata[32];
    assign item.delay    = s_tdata[33];

    tpdma_core u_core
    (
        .cur    (state_reg),
        .item   (item),
        .compat (compat_reg),
        .turbo  (turbo_reg),
        .nxt    (state_next),
        .res    (res)
    );

    // config writes must land only while idle; the user is bound to this, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compat_reg <= 1'b0;
            turbo_reg  <= 2'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tpdma_pkg::CFG_COMPAT: compat_reg <= cfg_wdata[0];
                default:               turbo_reg  <= cfg_wdata;
            endcase
        end
    end

    // controller state, updated once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= '0;
            state_reg.phase    <= tpdma_pkg::PH_IDLE;
            state_reg.wseq     <= tpdma_pkg::WS_IDLE;
            state_reg.rmask    <= 8'h7F;
            state_reg.dir      <= 1'b1;
            state_reg.amode    <= 2'd1;
            state_reg.bmode    <= 2'd1;
            state_reg.xmode    <= 2'd1;
            state_reg.busreq_n <= 1'b1;
            state_reg.bao_n    <= 1'b0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // result payload, status fields reflect the state after the step
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {
                state_next.run,
                res.irq,
                !state_next.busreq_n && !item.grant_n,
                state_next.bao_n,
                state_next.busreq_n,
                state_next.dir ? state_next.aio : state_next.bio,
                state_next.src,
                res.wr_data,
                res.wr_is_io,
                res.wr_addr,
                res.wr_valid,
                res.rdata
            };
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

FILE: design/tpdma_checker.sv
`default_nettype none
`include "two_port_byte_dma_controller_assert.svh"
module tpdma_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [39:0] s_tdata,
    input wire [1:0]  s_tuser,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [55:0] m_tdata,
    input wire        cfg_we,
    input wire [0:0]  cfg_index,
    input wire [1:0]  cfg_wdata
);

    // stalled result must persist
    `TPDMA_AST_NXT(a_hold, m_tvalid && !m_tready, m_tvalid)
    // an empty result slot never blocks the input
    `TPDMA_AST_IMP(a_ready, !m_tvalid, s_tready)
    // block end only comes with a destination write
    `TPDMA_AST_IMP(a_irq_wr, m_tvalid && m_tdata[54], m_tdata[8])
    // no write means zeroed write fields
    `TPDMA_AST_IMP(a_wr_zero, m_tvalid && !m_tdata[8], m_tdata[33:9] == 25'd0)
    // owning the bus implies the request line is low
    `TPDMA_AST_IMP(a_hold_req, m_tvalid && m_tdata[53], !m_tdata[51])

endmodule

bind two_port_byte_dma_controller tpdma_checker u_tpdma_checker (.*);
`default_nettype wire

FILE: tb/tb_two_port_byte_dma_controller.sv
`default_nettype none
module tb_two_port_byte_dma_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import tpdma_pkg::*;

    // run limit in clock cycles, far above the slowest legal run
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 1700;

    // one result beat, unpacked into its fields
    typedef struct {
        logic [7:0]  rdata;
        logic        wr_valid;
        logic [15:0] wr_addr;
        logic        wr_is_io;
        logic [7:0]  wr_data;
        logic [15:0] src_addr;
        logic        src_is_io;
        logic        busreq_n;
        logic        bao_n;
        logic        holds_bus;
        logic        irq;
        logic        active;
    } dma_beat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // wdata, src_data, elapsed_cycles, grant_n, downstream_req_n, upstream_busy,
    // delay_req, zero pad
    logic [IN_DATA_W-1:0]  s_tdata;
    // req_type
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // rdata, wr_valid, wr_addr, wr_is_io, wr_data, src_addr, src_is_io, busreq_n,
    // bao_n, holds_bus, block_end_irq, active
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic [0:0]            cfg_index;
    logic [1:0]            cfg_wdata;

    two_port_byte_dma_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // expected result beats, oldest first
    dma_beat_t beat_q[$];

    int errors;
    int n_items;
    int n_beats;
    int n_copies;
    int n_block_ends;
    int cycles;

    // idling control: no_idle is shared by both sides, hold_off and rx_stall pace the result side
    bit no_idle;
    int hold_off;
    int rx_stall;

    // ---------------------------------------------------------------
    // controller model state
    // ---------------------------------------------------------------
    logic        c_compat;
    logic [1:0]  c_turbo;
    logic        p_run;
    phase_t      p_phase;
    wseq_t       p_wseq;
    logic [7:0]  p_base;
    logic [2:0]  p_rseq;
    logic [7:0]  p_rmask;
    logic [15:0] p_pa, p_pb, p_blen, p_src, p_dst, p_cnt;
    logic        p_dir, p_aio, p_bio;
    logic [1:0]  p_amode, p_bmode;
    logic [7:0]  p_presc;
    logic [1:0]  p_xmode;
    logic [2:0]  p_restart;
    logic [1:0]  p_status;
    logic [13:0] p_wtimer;
    logic        p_in_wait;
    logic        p_busreq_n, p_bao_n;
    logic        p_grant_n, p_down_n, p_up_busy, p_delay;
    dma_beat_t   p_out;

    function void model_reset();
        c_compat = 0; c_turbo = 0;
        p_run = 0; p_phase = PH_IDLE; p_wseq = WS_IDLE; p_base = 0;
        p_rseq = 0; p_rmask = 8'h7F;
        p_pa = 0; p_pb = 0; p_blen = 0; p_src = 0; p_dst = 0; p_cnt = 0;
        p_dir = 1; p_aio = 0; p_bio = 0; p_amode = 1; p_bmode = 1;
        p_presc = 0; p_xmode = 1; p_restart = 0; p_status = 0;
        p_wtimer = 0; p_in_wait = 0;
        p_grant_n = 0; p_down_n = 1; p_up_busy = 0; p_delay = 0;
        p_busreq_n = 1; p_bao_n = 0;
    endfunction

    function void set_lines(logic req_n, logic ao_n);
        p_busreq_n = req_n;
        p_bao_n = ao_n;
    endfunction

    // prescaler wait holds while the prescaler is nonzero and timer bits 13:5 are below it
    function bit wait_on();
        return p_presc != 0 && {1'b0, p_wtimer[13:5]} < {2'b0, p_presc};
    endfunction

    function void arbitrate();
        for (int i = 0; i < 2; i++) begin
            case (p_phase)
                PH_START: begin
                    if (!p_down_n || p_up_busy || p_delay) begin
                        set_lines(1, p_grant_n);
                        return;
                    end
                    set_lines(0, 1);
                    p_phase = PH_ACK;
                end
                PH_ACK: begin
                    if (!p_grant_n) p_phase = PH_XFER;
                    set_lines(p_busreq_n, 1);
                    return;
                end
                PH_XFER: begin
                    set_lines(0, 1);
                    return;
                end
                default: begin
                    set_lines(1, p_grant_n);
                    return;
                end
            endcase
        end
    endfunction

    // next enabled read slot at or after start, wrapping over the seven slots
    function void next_read(int start);
        int b;
        b = start;
        for (int i = 0; i < 7; i++) begin
            if (b >= 7) b -= 7;
            if (p_rmask[b]) begin
                p_rseq = b[2:0];
                return;
            end
            b++;
        end
        p_rseq = 0;
    endfunction

    function void preset_count();
        p_cnt = c_compat ? 16'hFFFF : 16'h0000;
    endfunction

    function void do_load();
        p_status[1] = 0;
        if (p_dir) begin
            p_src = p_pa;
            p_dst = p_pb;
        end
        else begin
            p_src = p_pb;
            p_dst = p_pa;
        end
        preset_count();
    endfunction

    function void go_idle();
        p_run = 0;
        p_phase = PH_IDLE;
        set_lines(1, p_grant_n);
        p_in_wait = 0;
    endfunction

    function void enable_run();
        p_run = 1;
        p_phase = PH_START;
        p_status[0] = 0;
        p_in_wait = 0;
    endfunction

    function void r6_command(logic [7:0] v);
        p_wseq = WS_IDLE;
        case (v)
            CMD_RESET: begin
                go_idle();
                p_status = 0;
                p_presc = 0;
                p_restart[1:0] = 0;
            end
            CMD_LOAD:     do_load();
            CMD_CONTINUE: begin
                p_status[1] = 0;
                preset_count();
            end
            CMD_RSTSEQ:   p_rseq = 0;
            CMD_CLRSTAT:  p_status = 0;
            CMD_INITRD:   next_read(0);
            CMD_ENABLE:   enable_run();
            CMD_DISABLE:  go_idle();
            CMD_RDMASK:   p_wseq = WS_R6B0;
            default: ;
        endcase
    endfunction

    // follow-on bytes of the base registers, in the order the base byte flags
    function void follow_byte(logic [7:0] v);
        wseq_t nx;
        nx = WS_IDLE;
        case (p_wseq)
            WS_R0B0: begin
                p_pa[7:0] = v;
                nx = p_base[4] ? WS_R0B1 : p_base[5] ? WS_R0B2 :
                     p_base[6] ? WS_R0B3 : WS_IDLE;
            end
            WS_R0B1: begin
                p_pa[15:8] = v;
                nx = p_base[5] ? WS_R0B2 : p_base[6] ? WS_R0B3 : WS_IDLE;
            end
            WS_R0B2: begin
                p_blen[7:0] = v;
                nx = p_base[6] ? WS_R0B3 : WS_IDLE;
            end
            WS_R0B3: p_blen[15:8] = v;
            WS_R1B0: nx = v[5] ? WS_R1B1 : WS_IDLE;
            WS_R2B0: nx = v[5] ? WS_R2B1 : WS_IDLE;
            WS_R2B1: p_presc = v;
            WS_R3B0: nx = p_base[4] ? WS_R3B1 : WS_IDLE;
            WS_R4B0: begin
                p_pb[7:0] = v;
                nx = p_base[3] ? WS_R4B1 : WS_IDLE;
            end
            WS_R4B1: p_pb[15:8] = v;
            WS_R6B0: begin
                p_rmask = v;
                next_read(0);
            end
            default: ;
        endcase
        p_wseq = nx;
    endfunction

    function void port_write(logic [7:0] v);
        if (p_wseq != WS_IDLE) follow_byte(v);
        else if ((v & 8'h83) == 8'h83) r6_command(v);
        else if ((v & 8'hC7) == 8'h82) begin
            // R5: ce/wait and auto-restart
            p_base = v;
            p_restart[1:0] = {v[5], v[4]};
        end
        else if ((v & 8'h83) == 8'h81) begin
            // R4: mode and port B address
            p_base = v;
            p_xmode = v[6:5];
            p_wseq = v[2] ? WS_R4B0 : v[3] ? WS_R4B1 : WS_IDLE;
        end
        else if ((v & 8'h83) == 8'h80) begin
            // R3: enable
            p_base = v;
            p_restart[2] = v[6];
            if (v[6]) enable_run();
            p_wseq = v[3] ? WS_R3B0 : v[4] ? WS_R3B1 : WS_IDLE;
        end
        else if ((v & 8'h87) == 8'h00) begin
            // R2: port B kind and address mode
            p_base = v;
            p_bio = v[3];
            p_bmode = v[5:4];
            p_wseq = v[6] ? WS_R2B0 : WS_IDLE;
        end
        else if ((v & 8'h87) == 8'h04) begin
            // R1: port A kind and address mode
            p_base = v;
            p_aio = v[3];
            p_amode = v[5:4];
            p_wseq = v[6] ? WS_R1B0 : WS_IDLE;
        end
        else if (!v[7] && v[1:0] != 0) begin
            // R0: direction, port A address, block length
            p_base = v;
            p_dir = v[2];
            p_wseq = v[3] ? WS_R0B0 : v[4] ? WS_R0B1 :
                     v[5] ? WS_R0B2 : v[6] ? WS_R0B3 : WS_IDLE;
        end
    endfunction

    function logic [7:0] port_read();
        logic [15:0] a, b;
        logic [7:0] r;
        a = p_dir ? p_src : p_dst;
        b = p_dir ? p_dst : p_src;
        case (p_rseq)
            3'd0:    r = (p_status[1] ? 8'h00 : 8'h20) | 8'h1A | {7'b0, p_status[0]};
            3'd1:    r = p_cnt[7:0];
            3'd2:    r = p_cnt[15:8];
            3'd3:    r = a[7:0];
            3'd4:    r = a[15:8];
            3'd5:    r = b[7:0];
            default: r = b[15:8];
        endcase
        next_read(int'(p_rseq) + 1);
        return r;
    endfunction

    function logic [15:0] addr_next(logic [15:0] a, logic [1:0] mode);
        if (mode == 2'd1) return a + 16'd1;
        if (mode == 2'd0) return a - 16'd1;
        return a;
    endfunction

    function void do_transfer(logic [7:0] data);
        logic [1:0] sm, dm;
        logic dio;
        if (!p_run) return;
        if (p_in_wait) begin
            if (wait_on()) return;
            p_in_wait = 0;
        end
        arbitrate();
        if (p_phase != PH_XFER) return;
        sm = p_dir ? p_amode : p_bmode;
        dm = p_dir ? p_bmode : p_amode;
        dio = p_dir ? p_bio : p_aio;
        p_wtimer = 0;
        p_out.wr_valid = 1;
        p_out.wr_addr = p_dst;
        p_out.wr_is_io = dio;
        p_out.wr_data = data;
        p_cnt = p_cnt + 16'd1;
        p_status[0] = 1;
        p_src = addr_next(p_src, sm);
        p_dst = addr_next(p_dst, dm);
        if (p_cnt >= p_blen) begin
            // block end: reload and re-arbitrate, or stop
            p_status[1] = 1;
            p_out.irq = 1;
            if (p_restart[1]) begin
                do_load();
                p_phase = PH_START;
            end
            else begin
                p_run = 0;
                p_phase = PH_IDLE;
                set_lines(1, p_grant_n);
            end
            p_in_wait = 0;
            return;
        end
        if (p_delay) begin
            p_phase = PH_START;
            set_lines(1, p_grant_n);
            return;
        end
        if (wait_on()) begin
            p_in_wait = 1;
            if (p_xmode == 2'd2) begin
                // burst mode lets go of the bus while waiting
                p_phase = PH_WAITC;
                set_lines(1, p_grant_n);
            end
        end
    endfunction

    function void timer_advance(logic [13:0] n);
        logic [31:0] sum;
        sum = p_wtimer + (32'd8 >> c_turbo) * n;
        p_wtimer = sum[13:0];
        if (p_phase == PH_WAITC && !wait_on()) begin
            p_phase = PH_START;
            arbitrate();
        end
    endfunction

    function dma_beat_t dma_model_step(item_t it);
        p_out = '{default: 0};
        p_grant_n = it.grant_n;
        p_down_n = it.down_n;
        p_up_busy = it.up_busy;
        p_delay = it.delay;
        case (req_t'(it.req))
            REQ_WRITE: port_write(it.wdata);
            REQ_READ:  p_out.rdata = port_read();
            REQ_XFER:  do_transfer(it.src_data);
            default:   timer_advance(it.elapsed);
        endcase
        p_out.src_addr = p_src;
        p_out.src_is_io = p_dir ? p_aio : p_bio;
        p_out.busreq_n = p_busreq_n;
        p_out.bao_n = p_bao_n;
        p_out.holds_bus = !p_busreq_n && !p_grant_n;
        p_out.active = p_run;
        return p_out;
    endfunction

    // ---------------------------------------------------------------
    // clock, reset, watchdog
    // ---------------------------------------------------------------
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d beats outstanding",
                         cycles, beat_q.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // result side: stalls drawn per beat, plus a long hold-off on request
    // ---------------------------------------------------------------
    initial
    begin
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                m_tready <= 0;
                hold_off--;
            end
            else if (rx_stall > 0)
            begin
                m_tready <= 0;
                rx_stall--;
            end
            else
                m_tready <= 1;
        end
    end

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h (beat %0d)",
                 $time, what, got, want, n_beats);
    endtask

    // compare every accepted result beat with the oldest expectation
    always @(posedge clk)
    begin
        dma_beat_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.rdata     = m_tdata[7:0];
            got.wr_valid  = m_tdata[8];
            got.wr_addr   = m_tdata[24:9];
            got.wr_is_io  = m_tdata[25];
            got.wr_data   = m_tdata[33:26];
            got.src_addr  = m_tdata[49:34];
            got.src_is_io = m_tdata[50];
            got.busreq_n  = m_tdata[51];
            got.bao_n     = m_tdata[52];
            got.holds_bus = m_tdata[53];
            got.irq       = m_tdata[54];
            got.active    = m_tdata[55];
            if (beat_q.size() == 0)
                report("unexpected beat", m_tdata, 0);
            else
            begin
                want = beat_q.pop_front();
                if (got.rdata !== want.rdata) report("rdata", got.rdata, want.rdata);
                if (got.wr_valid !== want.wr_valid)
                    report("wr_valid", got.wr_valid, want.wr_valid);
                if (got.wr_addr !== want.wr_addr)
                    report("wr_addr", got.wr_addr, want.wr_addr);
                if (got.wr_is_io !== want.wr_is_io)
                    report("wr_is_io", got.wr_is_io, want.wr_is_io);
                if (got.wr_data !== want.wr_data)
                    report("wr_data", got.wr_data, want.wr_data);
                if (got.src_addr !== want.src_addr)
                    report("src_addr", got.src_addr, want.src_addr);
                if (got.src_is_io !== want.src_is_io)
                    report("src_is_io", got.src_is_io, want.src_is_io);
                if (got.busreq_n !== want.busreq_n)
                    report("busreq_n", got.busreq_n, want.busreq_n);
                if (got.bao_n !== want.bao_n) report("bao_n", got.bao_n, want.bao_n);
                if (got.holds_bus !== want.holds_bus)
                    report("holds_bus", got.holds_bus, want.holds_bus);
                if (got.irq !== want.irq) report("block_end_irq", got.irq, want.irq);
                if (got.active !== want.active) report("active", got.active, want.active);
                if (want.wr_valid) n_copies++;
                if (want.irq) n_block_ends++;
            end
            n_beats++;
            rx_stall = no_idle ? 0 : $urandom_range(0, 14);
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // item with random side fields; bus inputs lean toward granting the bus
    function automatic item_t make_item(req_t r, logic [7:0] w);
        item_t it;
        it.req      = r;
        it.wdata    = w;
        it.src_data = $urandom_range(0, 255);
        it.elapsed  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                                  : $urandom_range(0, 40);
        it.grant_n  = ($urandom_range(0, 3) == 0);
        it.down_n   = ($urandom_range(0, 5) != 0);
        it.up_busy  = ($urandom_range(0, 7) == 0);
        it.delay    = ($urandom_range(0, 9) == 0);
        return it;
    endfunction

    // drive one beat after a random gap unless no_idle is set; called and returns at a falling edge
    task automatic send_beat(item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= it.req;
        s_tdata  <= {6'b0, it.delay, it.up_busy, it.down_n, it.grant_n,
                     it.elapsed, it.src_data, it.wdata};
        do @(posedge clk); while (!s_tready);
        beat_q.push_back(dma_model_step(it));
        n_items++;
        @(negedge clk);
    endtask

    task automatic wr(logic [7:0] v);
        send_beat(make_item(REQ_WRITE, v));
    endtask

    task automatic rd();
        send_beat(make_item(REQ_READ, 8'h00));
    endtask

    // transfer with the bus free and granted
    task automatic xfer_granted();
        item_t it;
        it = make_item(REQ_XFER, 8'h00);
        it.grant_n = 0;
        it.down_n = 1;
        it.up_busy = 0;
        it.delay = 0;
        send_beat(it);
    endtask

    // sender stops until every expected beat is back, then lets the block settle
    task automatic drain();
        s_tvalid <= 0;
        @(negedge clk);
        while (beat_q.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic cfg_write(logic [0:0] idx, logic [1:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 0;
        if (idx == CFG_COMPAT) c_compat = val[0];
        else c_turbo = val;
    endtask

    // random but well-formed programming of one block, then load and enable
    task automatic program_block();
        logic [15:0] len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12);
        // R0 with direction and all four follow-on bytes
        wr(8'h79 | ($urandom_range(0, 1) << 2));
        wr($urandom_range(0, 255));
        wr($urandom_range(0, 255));
        wr(len[7:0]);
        wr(len[15:8]);
        // R1 and R2: port kind and address mode, R2 may carry a prescaler
        wr(8'h44 | ($urandom_range(0, 1) << 3) | ($urandom_range(0, 3) << 4));
        wr($urandom_range(0, 255) & 8'hDF);
        wr(8'h40 | ($urandom_range(0, 1) << 3) | ($urandom_range(0, 3) << 4));
        if ($urandom_range(0, 1))
        begin
            wr(8'h20 | $urandom_range(0, 3));
            wr(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 2));
        end
        else
            wr($urandom_range(0, 255) & 8'hDF);
        // R4: transfer mode and port B address
        wr(8'h8D | ($urandom_range(0, 3) << 5));
        wr($urandom_range(0, 255));
        wr($urandom_range(0, 255));
        // R5: auto-restart and ce/wait
        wr(8'h82 | ($urandom_range(0, 3) << 4));
        wr(CMD_LOAD);
        if ($urandom_range(0, 3) == 0) wr(8'hC0);
        else wr(CMD_ENABLE);
    endtask

    // transfer traffic with reads, timer advances and the odd command
    task automatic run_traffic(int n);
        int k;
        logic [7:0] cmds[8];
        cmds = '{CMD_CONTINUE, CMD_DISABLE, CMD_ENABLE, CMD_INITRD,
                 CMD_CLRSTAT, CMD_RSTSEQ, CMD_RESET, CMD_RDMASK};
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 60) send_beat(make_item(REQ_XFER, 8'h00));
            else if (k < 75) send_beat(make_item(REQ_TIMER, 8'h00));
            else if (k < 92) rd();
            else
            begin
                k = $urandom_range(0, 7);
                wr(cmds[k]);
                if (cmds[k] == CMD_RDMASK) wr($urandom_range(0, 255));
                else if (cmds[k] == CMD_DISABLE || cmds[k] == CMD_RESET) wr(CMD_ENABLE);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        // default mask walks all seven read slots
        repeat (7) rd();
        // unknown command and a byte matching no base register
        wr(8'hFF);
        wr(8'hC2);
        // copy from idle does nothing
        send_beat(make_item(REQ_XFER, 8'h00));
        // A to B, port A at the top of memory, three bytes
        wr(8'h7D); wr(8'hFF); wr(8'hFF); wr(8'h03); wr(8'h00);
        // port A in i/o space stepping down, port B fixed address
        wr(8'h4C); wr(8'h00);
        wr(8'h28);
        // burst mode, port B at 0x8000
        wr(8'hCD); wr(8'h00); wr(8'h80);
        wr(CMD_LOAD);
        wr(CMD_ENABLE);
        repeat (4) xfer_granted();
        // empty read mask keeps reads on status
        wr(CMD_RDMASK); wr(8'h00);
        rd(); rd();
        begin
            item_t it;
            it = make_item(REQ_TIMER, 8'h00);
            it.elapsed = 14'h3FFF;
            send_beat(it);
        end
        wr(CMD_RDMASK); wr(8'h7F);
    endtask

    task automatic test_random();
        int round;
        item_t it;
        round = 0;
        while (n_items < RANDOM_ITEMS)
        begin
            // every sixth round, go idle and move to another register setting
            if (round % 6 == 0)
            begin
                drain();
                cfg_write(CFG_COMPAT, $urandom_range(0, 1));
                cfg_write(CFG_TURBO, $urandom_range(0, 3));
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 4) != 0)
            begin
                program_block();
                run_traffic($urandom_range(10, 40));
            end
            else
            begin
                // noise: any kind, any byte, any field value
                repeat (10)
                begin
                    it = make_item(req_t'($urandom_range(0, 3)), $urandom_range(0, 255));
                    it.src_data = $urandom_range(0, 255);
                    it.elapsed = $urandom_range(0, 16383);
                    it.grant_n = $urandom_range(0, 1);
                    it.down_n = $urandom_range(0, 1);
                    it.up_busy = $urandom_range(0, 1);
                    it.delay = $urandom_range(0, 1);
                    send_beat(it);
                end
            end
            round++;
        end
        no_idle = 0;
    endtask

    // result side holds off while items keep coming, so the input stalls
    task automatic test_backpressure();
        drain();
        hold_off = 300;
        no_idle = 1;
        program_block();
        run_traffic(40);
        no_idle = 0;
    endtask

    // sender pauses until every result is back, then carries on
    task automatic test_pause();
        program_block();
        run_traffic(20);
        drain();
        run_traffic(20);
    endtask

    task automatic test_config_extremes();
        drain();
        cfg_write(CFG_COMPAT, 1);
        cfg_write(CFG_TURBO, 3);
        program_block();
        run_traffic(30);
        drain();
        cfg_write(CFG_COMPAT, 0);
        cfg_write(CFG_TURBO, 0);
        program_block();
        run_traffic(30);
    endtask

    initial
    begin
        errors = 0; n_items = 0; n_beats = 0; n_copies = 0; n_block_ends = 0;
        no_idle = 0; hold_off = 0; rx_stall = 0;
        rst_n = 0;
        s_tvalid = 0; s_tdata = '0; s_tuser = '0;
        cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
        model_reset();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_pause();
        test_random();

        // wait for the last beats, then leave room for anything stray
        drain();
        repeat (4) @(posedge clk);

        $display("covered %0d items and %0d result beats: %0d byte copies, %0d block ends",
                 n_items, n_beats, n_copies, n_block_ends);
        $display("under random stalls, a long hold-off and all register settings");
        if (errors == 0 && beat_q.size() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d beats missing", errors, beat_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
